@@ rtl/awt_pkg.sv @@
package awt_pkg;

	localparam int WATCH_ENTRIES = 16;
	localparam int NUM_SPACES    = 8;
	localparam int IDX_W         = (WATCH_ENTRIES > 1) ? $clog2(WATCH_ENTRIES) : 1;

	localparam logic [1:0] OP_ACCESS = 2'd0;
	localparam logic [1:0] OP_REG    = 2'd1;
	localparam logic [1:0] OP_UNREG  = 2'd2;

	localparam logic [1:0] KIND_LOAD  = 2'd1;
	localparam logic [1:0] KIND_STORE = 2'd2;

	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_FULL = 2'd3;

	localparam logic [1:0] CFG_DIM_X = 2'd0;
	localparam logic [1:0] CFG_DIM_Y = 2'd1;
	localparam logic [1:0] CFG_DIM_Z = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture the input item
		logic scan;      // examine entry scan_idx
		logic commit;    // apply table update
		logic div_start; // start coordinate divisions
		logic div_step;  // one restoring step
		logic div_next;  // move to next division stage
		logic emit;      // load the output register
	} awt_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_last;
		logic div_last;
		logic div_stage_last;
		logic hit;
	} awt_stat_t;

endpackage

@@ rtl/address_range_watchpoint_table.sv @@
// Watchpoint table of byte ranges, tagged by address space.
// Input channel in_valid/in_ready carries one item: op (access, register,
// unregister), space, address, region size and access fields.
// Output channel out_valid/out_ready returns exactly one item per input:
// event kind (none, load hit, store hit, table full), matched range,
// thread x/y/z and passed-through pc, size and block index.
// Configuration: cfg_we/cfg_index/cfg_data write block dimensions x, y, z;
// write only while the block is idle. A zero dimension acts as one.
// Sequence: an accept step, a scan of all 16 entries (one entry per cycle), a
// commit, then on a hit three 10-bit restoring divisions (one quotient bit per
// cycle), then an emit. One item is in flight at a time; the entry scan sets
// the rate of a miss, the three divisions dominate a hit.
// Reset clears all valid bits and sets every dimension to one.
// If the receiver stalls, the result holds in the output register; one more
// item is taken and processed, then holds in emit until the register frees.
module address_range_watchpoint_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [2:0]  addr_space,
	input  logic [63:0] address,
	input  logic [31:0] region_size,
	input  logic [1:0]  access_kind,
	input  logic [9:0]  thread_id,
	input  logic [31:0] pc_in,
	input  logic [7:0]  bytes_in,
	input  logic [15:0] block_x_in,
	input  logic [15:0] block_y_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  event_kind,
	output logic [63:0] watch_base,
	output logic [31:0] watch_size,
	output logic [9:0]  thread_x,
	output logic [9:0]  thread_y,
	output logic [5:0]  thread_z,
	output logic [31:0] pc_out,
	output logic [7:0]  bytes_out,
	output logic [15:0] block_x_out,
	output logic [15:0] block_y_out
);
	import awt_pkg::*;

	awt_cmd_t  cmd;
	awt_stat_t stat;

	// sequence scan, update, divide and emit
	awt_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd
	);

	// hold the table, dimensions, divider and output register
	awt_dpath u_dpath (
		.clk, .arst_n, .cmd, .stat, .cfg_we, .cfg_index, .cfg_data,
		.op, .addr_space, .address, .region_size, .access_kind, .thread_id,
		.pc_in, .bytes_in, .block_x_in, .block_y_in, .out_ready, .out_valid,
		.event_kind, .watch_base, .watch_size, .thread_x, .thread_y, .thread_z,
		.pc_out, .bytes_out, .block_x_out, .block_y_out
	);
endmodule

@@ rtl/awt_ctrl.sv @@
module awt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               out_valid,
	input  logic               out_ready,
	input  awt_pkg::awt_stat_t stat,
	output awt_pkg::awt_cmd_t  cmd
);
	import awt_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_COMMIT, S_DIV, S_EMIT} state_t;
	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		case (state_q)
			S_SCAN:   cmd.scan = 1'b1;
			S_COMMIT: begin
				cmd.commit    = 1'b1;
				cmd.div_start = 1'b1;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cmd.div_next = stat.div_last;
			end
			S_EMIT:   cmd.emit = !out_valid || out_ready;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:   if (in_valid) state_q <= S_SCAN;
				S_SCAN:   if (stat.scan_last) state_q <= S_COMMIT;
				S_COMMIT: state_q <= stat.hit ? S_DIV : S_EMIT;
				S_DIV:    if (stat.div_last && stat.div_stage_last) state_q <= S_EMIT;
				S_EMIT:   if (!out_valid || out_ready) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/awt_dpath.sv @@
module awt_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  awt_pkg::awt_cmd_t cmd,
	output awt_pkg::awt_stat_t stat,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [10:0]       cfg_data,
	input  logic [1:0]        op,
	input  logic [2:0]        addr_space,
	input  logic [63:0]       address,
	input  logic [31:0]       region_size,
	input  logic [1:0]        access_kind,
	input  logic [9:0]        thread_id,
	input  logic [31:0]       pc_in,
	input  logic [7:0]        bytes_in,
	input  logic [15:0]       block_x_in,
	input  logic [15:0]       block_y_in,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [1:0]        event_kind,
	output logic [63:0]       watch_base,
	output logic [31:0]       watch_size,
	output logic [9:0]        thread_x,
	output logic [9:0]        thread_y,
	output logic [5:0]        thread_z,
	output logic [31:0]       pc_out,
	output logic [7:0]        bytes_out,
	output logic [15:0]       block_x_out,
	output logic [15:0]       block_y_out
);
	import awt_pkg::*;

	logic [WATCH_ENTRIES-1:0] valid_q;
	logic [63:0] base_q  [WATCH_ENTRIES];
	logic [31:0] len_q   [WATCH_ENTRIES];
	logic [2:0]  space_q [WATCH_ENTRIES];

	logic [10:0] dim_x_q, dim_y_q;
	logic [6:0]  dim_z_q;

	logic [1:0]  op_q, kind_q;
	logic [2:0]  sp_q;
	logic [63:0] addr_q;
	logic [31:0] rsize_q, pc_q;
	logic [7:0]  bytes_q;
	logic [15:0] bx_q, by_q;

	logic [IDX_W-1:0] scan_idx_q;
	logic             exact_q, free_q, best_q;
	logic [IDX_W-1:0] exact_idx_q, free_idx_q, best_idx_q;
	logic [63:0]      best_base_q;

	// coordinate divider: stage 0 tid/x, stage 1 q/y, stage 2 q/z
	logic [1:0]  stage_q;
	logic [3:0]  bit_q;
	logic [9:0]  quo_q, rem_q;
	logic [10:0] divisor;
	logic [9:0]  tx_q, ty_q;
	logic [5:0]  tz_q;
	logic [1:0]  ev_q;

	logic space_ok;
	assign space_ok = (32'(sp_q) < NUM_SPACES);

	// one entry per cycle
	logic [63:0] diff;
	logic        e_match, e_exact, e_cover;
	assign e_match = valid_q[scan_idx_q] && (space_q[scan_idx_q] == sp_q);
	assign e_exact = e_match && (base_q[scan_idx_q] == addr_q);
	assign diff    = addr_q - base_q[scan_idx_q];
	assign e_cover = e_match && (base_q[scan_idx_q] <= addr_q) &&
		((diff == 64'd0) || (diff < {32'd0, len_q[scan_idx_q]}));

	assign stat.scan_last = (32'(scan_idx_q) == WATCH_ENTRIES - 1);
	assign stat.hit = space_ok && (op_q == OP_ACCESS) && best_q &&
		((kind_q == KIND_LOAD) || (kind_q == KIND_STORE));

	always_comb begin
		case (stage_q)
			2'd0:    divisor = (dim_x_q == '0) ? 11'd1 : dim_x_q;
			2'd1:    divisor = (dim_y_q == '0) ? 11'd1 : dim_y_q;
			default: divisor = (dim_z_q == '0) ? 11'd1 : {4'd0, dim_z_q};
		endcase
	end
	assign stat.div_last       = (bit_q == 4'd0);
	assign stat.div_stage_last = (stage_q == 2'd2);

	// dividend bits enter most significant first
	logic [10:0] trial;
	logic        ge;
	assign trial = {rem_q, quo_q[bit_q]};
	assign ge    = (trial >= divisor);
	logic [10:0] new_rem;
	assign new_rem = ge ? trial - divisor : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			dim_x_q   <= 11'd1;
			dim_y_q   <= 11'd1;
			dim_z_q   <= 7'd1;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_DIM_X: dim_x_q <= cfg_data;
					CFG_DIM_Y: dim_y_q <= cfg_data;
					CFG_DIM_Z: dim_z_q <= cfg_data[6:0];
					default:   ;
				endcase
			end
			if (cmd.commit && space_ok) begin
				if (op_q == OP_REG && (exact_q || free_q)) begin
					valid_q[exact_q ? exact_idx_q : free_idx_q] <= 1'b1;
				end else if (op_q == OP_UNREG && exact_q) begin
					valid_q[exact_idx_q] <= 1'b0;
				end
			end
			if (cmd.emit) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op; sp_q <= addr_space; addr_q <= address; rsize_q <= region_size;
			kind_q <= access_kind; pc_q <= pc_in; bytes_q <= bytes_in;
			bx_q <= block_x_in; by_q <= block_y_in;
			quo_q <= thread_id;
			scan_idx_q <= '0;
			exact_q <= 1'b0; free_q <= 1'b0; best_q <= 1'b0;
		end
		if (cmd.scan) begin
			scan_idx_q <= scan_idx_q + 1'b1;
			if (e_exact && !exact_q) begin
				exact_q <= 1'b1; exact_idx_q <= scan_idx_q;
			end
			if (!valid_q[scan_idx_q] && !free_q) begin
				free_q <= 1'b1; free_idx_q <= scan_idx_q;
			end
			if (e_cover && (!best_q || base_q[scan_idx_q] > best_base_q)) begin
				best_q <= 1'b1; best_idx_q <= scan_idx_q; best_base_q <= base_q[scan_idx_q];
			end
		end
		if (cmd.commit) begin
			if (stat.hit)
				ev_q <= kind_q;
			else if (space_ok && op_q == OP_REG && !(exact_q || free_q))
				ev_q <= EV_FULL;
			else
				ev_q <= EV_NONE;
			if (space_ok && op_q == OP_REG && (exact_q || free_q)) begin
				base_q[exact_q ? exact_idx_q : free_idx_q]  <= addr_q;
				len_q[exact_q ? exact_idx_q : free_idx_q]   <= rsize_q;
				space_q[exact_q ? exact_idx_q : free_idx_q] <= sp_q;
			end
		end
		if (cmd.div_start) begin
			stage_q <= 2'd0; bit_q <= 4'd9; rem_q <= '0;
		end
		if (cmd.div_step) begin
			quo_q[bit_q] <= ge;
			if (cmd.div_next) begin
				case (stage_q)
					2'd0:    tx_q <= new_rem[9:0];
					2'd1:    ty_q <= new_rem[9:0];
					default: tz_q <= new_rem[5:0];
				endcase
				stage_q <= stage_q + 1'b1;
				bit_q   <= 4'd9;
				rem_q   <= '0;
			end else begin
				rem_q <= new_rem[9:0];
				bit_q <= bit_q - 1'b1;
			end
		end
		if (cmd.emit) begin
			event_kind <= ev_q;
			if (ev_q == KIND_LOAD || ev_q == KIND_STORE) begin
				watch_base <= base_q[best_idx_q]; watch_size <= len_q[best_idx_q];
				thread_x <= tx_q; thread_y <= ty_q; thread_z <= tz_q;
				pc_out <= pc_q; bytes_out <= bytes_q;
				block_x_out <= bx_q; block_y_out <= by_q;
			end else begin
				watch_base <= '0; watch_size <= '0;
				thread_x <= '0; thread_y <= '0; thread_z <= '0;
				pc_out <= '0; bytes_out <= '0; block_x_out <= '0; block_y_out <= '0;
			end
		end
	end
endmodule

@@ rtl/awt_checker.sv @@
module awt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] event_kind,
	input logic [63:0] watch_base
);
	import awt_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_kind))
		else $error("result dropped under stall");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while busy");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind == EV_NONE || event_kind == EV_FULL) |-> watch_base == 64'd0)
		else $error("nonzero base without hit");

	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("output valid after reset");
endmodule

bind address_range_watchpoint_table awt_checker u_awt_checker (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .event_kind, .watch_base
);

@@ dv/address_range_watchpoint_table_test.sv @@
module address_range_watchpoint_table_test;
	import awt_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [10:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic [2:0]  addr_space;
	logic [63:0] address;
	logic [31:0] region_size;
	logic [1:0]  access_kind;
	logic [9:0]  thread_id;
	logic [31:0] pc_in;
	logic [7:0]  bytes_in;
	logic [15:0] block_x_in;
	logic [15:0] block_y_in;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  event_kind;
	logic [63:0] watch_base;
	logic [31:0] watch_size;
	logic [9:0]  thread_x;
	logic [9:0]  thread_y;
	logic [5:0]  thread_z;
	logic [31:0] pc_out;
	logic [7:0]  bytes_out;
	logic [15:0] block_x_out;
	logic [15:0] block_y_out;

	address_range_watchpoint_table dut (.*);

	typedef struct packed {
		logic [1:0]  op;
		logic [2:0]  sp;
		logic [63:0] addr;
		logic [31:0] len;
		logic [1:0]  kind;
		logic [9:0]  tid;
		logic [31:0] pc;
		logic [7:0]  nbytes;
		logic [15:0] bx;
		logic [15:0] by;
	} watch_req_t;

	typedef struct packed {
		logic [1:0]  ev;
		logic [63:0] base;
		logic [31:0] size;
		logic [9:0]  tx;
		logic [9:0]  ty;
		logic [5:0]  tz;
		logic [31:0] pc;
		logic [7:0]  nbytes;
		logic [15:0] bx;
		logic [15:0] by;
	} watch_event_t;

	// Directed row: the request plus an optional typed-in event.
	typedef struct {
		watch_req_t   req;
		bit           typed;
		watch_event_t ev;
	} directed_row_t;

	// Shadow of the watch table and the block dimensions.
	logic        shadow_valid [WATCH_ENTRIES];
	logic [63:0] shadow_base  [WATCH_ENTRIES];
	logic [31:0] shadow_len   [WATCH_ENTRIES];
	logic [2:0]  shadow_space [WATCH_ENTRIES];
	logic [10:0] dim_x, dim_y;
	logic [6:0]  dim_z;

	watch_event_t pending_events [$];
	int errors = 0;
	int n_sent = 0;
	int n_hits = 0;
	int n_full = 0;
	int idle_in_pct = 0;
	int stall_out_pct = 0;
	bit long_hold = 0;
	int quiet_cycles = 0;
	localparam int QUIET_LIMIT = 20000;

	// Predict the event for one request and update the shadow table.
	function automatic watch_event_t predict_watch_event(watch_req_t r);
		watch_event_t e;
		int hit, slot;
		int unsigned ux, uy, uz;
		e = '0;
		hit = -1;
		slot = -1;
		if (int'(r.sp) >= NUM_SPACES)
			return e;
		if (r.op == OP_REG || r.op == OP_UNREG) begin
			for (int i = 0; i < WATCH_ENTRIES; i++)
				if (slot < 0 && shadow_valid[i] && shadow_space[i] == r.sp &&
						shadow_base[i] == r.addr)
					slot = i;
		end
		if (r.op == OP_REG) begin
			if (slot < 0)
				for (int i = 0; i < WATCH_ENTRIES; i++)
					if (slot < 0 && !shadow_valid[i])
						slot = i;
			if (slot < 0) begin
				e.ev = EV_FULL;
				return e;
			end
			shadow_valid[slot] = 1'b1;
			shadow_base[slot] = r.addr;
			shadow_len[slot] = r.len;
			shadow_space[slot] = r.sp;
		end else if (r.op == OP_UNREG) begin
			if (slot >= 0)
				shadow_valid[slot] = 1'b0;
		end else if (r.op == OP_ACCESS && (r.kind == KIND_LOAD || r.kind == KIND_STORE)) begin
			for (int i = 0; i < WATCH_ENTRIES; i++) begin
				if (!shadow_valid[i] || shadow_space[i] != r.sp || shadow_base[i] > r.addr)
					continue;
				// exact base hits even with zero length
				if ((r.addr == shadow_base[i] ||
						(r.addr - shadow_base[i]) < {32'd0, shadow_len[i]}) &&
						(hit < 0 || shadow_base[i] > shadow_base[hit]))
					hit = i;
			end
			if (hit >= 0) begin
				ux = (dim_x == 0) ? 1 : dim_x;
				uy = (dim_y == 0) ? 1 : dim_y;
				uz = (dim_z == 0) ? 1 : dim_z;
				e.ev = r.kind;
				e.base = shadow_base[hit];
				e.size = shadow_len[hit];
				e.tx = 10'(r.tid % ux);
				e.ty = 10'((r.tid / ux) % uy);
				e.tz = 6'((r.tid / (ux * uy)) % uz);
				e.pc = r.pc;
				e.nbytes = r.nbytes;
				e.bx = r.bx;
				e.by = r.by;
			end
		end
		return e;
	endfunction

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Receiver: stall at the phase's rate, or hold off entirely when asked.
	always @(negedge clk) begin
		if (long_hold)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= stall_out_pct);
	end

	// Check every accepted result against the oldest prediction.
	always @(posedge clk) begin
		watch_event_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_events.size() == 0) begin
				$error("result with no prediction pending: event_kind %0d", event_kind);
				errors++;
			end else begin
				want = pending_events.pop_front();
				if (want.ev != 0)
					n_hits += (want.ev == EV_FULL) ? 0 : 1;
				if (want.ev == EV_FULL)
					n_full++;
				if (event_kind !== want.ev) begin
					$error("event_kind exp %0d got %0d", want.ev, event_kind); errors++;
				end
				if (watch_base !== want.base) begin
					$error("watch_base exp %h got %h", want.base, watch_base); errors++;
				end
				if (watch_size !== want.size) begin
					$error("watch_size exp %h got %h", want.size, watch_size); errors++;
				end
				if (thread_x !== want.tx) begin
					$error("thread_x exp %0d got %0d", want.tx, thread_x); errors++;
				end
				if (thread_y !== want.ty) begin
					$error("thread_y exp %0d got %0d", want.ty, thread_y); errors++;
				end
				if (thread_z !== want.tz) begin
					$error("thread_z exp %0d got %0d", want.tz, thread_z); errors++;
				end
				if (pc_out !== want.pc) begin
					$error("pc_out exp %h got %h", want.pc, pc_out); errors++;
				end
				if (bytes_out !== want.nbytes) begin
					$error("bytes_out exp %0d got %0d", want.nbytes, bytes_out); errors++;
				end
				if (block_x_out !== want.bx) begin
					$error("block_x_out exp %0d got %0d", want.bx, block_x_out); errors++;
				end
				if (block_y_out !== want.by) begin
					$error("block_y_out exp %0d got %0d", want.by, block_y_out); errors++;
				end
			end
		end
	end

	// Watchdog: count cycles with no item moving on either side, outside a long hold.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else if (long_hold)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("address_range_watchpoint_table_test: errors");
			$finish;
		end
	end

	// Offer one request; hold it until accepted, then predict.
	// Valid stays high after acceptance; the next call replaces or drops it, or the caller drops it.
	task automatic send_request(watch_req_t r);
		while ($urandom_range(99) < idle_in_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= r.op;
		addr_space <= r.sp;
		address <= r.addr;
		region_size <= r.len;
		access_kind <= r.kind;
		thread_id <= r.tid;
		pc_in <= r.pc;
		bytes_in <= r.nbytes;
		block_x_in <= r.bx;
		block_y_in <= r.by;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_events.insert(pending_events.size(), predict_watch_event(r));
		n_sent++;
		@(negedge clk);
	endtask

	// Drain, let the last ignored item finish, then write the three dimensions.
	task automatic write_dims(logic [10:0] x, logic [10:0] y, logic [6:0] z);
		in_valid <= 1'b0;
		while (pending_events.size() != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_DIM_X;
		cfg_data <= x;
		@(negedge clk);
		cfg_index <= CFG_DIM_Y;
		cfg_data <= y;
		@(negedge clk);
		cfg_index <= CFG_DIM_Z;
		cfg_data <= {4'd0, z};
		@(negedge clk);
		cfg_we <= 1'b0;
		dim_x = x;
		dim_y = y;
		dim_z = z;
	endtask

	function automatic watch_req_t mk(int o, int s, logic [63:0] a,
			logic [31:0] l, int k, int t);
		watch_req_t r;
		r = '{2'(o), 3'(s), a, l, 2'(k), 10'(t), $urandom, 8'($urandom), 16'($urandom),
			16'($urandom)};
		return r;
	endfunction

	// Random request: mostly accesses near registered bases in a few spaces.
	function automatic watch_req_t random_request();
		watch_req_t r;
		int pick;
		logic [63:0] bases [4] = '{64'd0, 64'h1000, 64'hFFFF_FFFF_FFFF_FF00, 64'h8000_0000};
		pick = $urandom_range(99);
		r = mk(OP_ACCESS, 3'($urandom_range(3)), bases[$urandom_range(3)] +
			64'($urandom_range(300)), $urandom_range(400), 2'($urandom_range(3)),
			10'($urandom));
		if (pick < 3)
			r.addr = {$urandom, $urandom};
		if (pick < 2)
			r.sp = 3'($urandom);
		if (pick >= 60 && pick < 80) begin
			r.op = OP_REG;
			if ($urandom_range(9) == 0)
				r.len = $urandom;
		end else if (pick >= 80 && pick < 96) begin
			r.op = OP_UNREG;
		end else if (pick >= 96) begin
			r.op = 2'($urandom);
		end
		return r;
	endfunction

	initial begin
		directed_row_t rows [$];
		watch_event_t none_ev;
		watch_event_t probe_ev;
		int phase_pcts [4][2];
		phase_pcts = '{'{0, 0}, '{85, 0}, '{0, 85}, '{31, 31}};
		cfg_we = 1'b0;
		cfg_index = CFG_DIM_X;
		cfg_data = '0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		{op, addr_space, address, region_size, access_kind, thread_id} = '0;
		{pc_in, bytes_in, block_x_in, block_y_in} = '0;
		for (int i = 0; i < WATCH_ENTRIES; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_base[i] = '0;
			shadow_len[i] = '0;
			shadow_space[i] = '0;
		end
		dim_x = 1;
		dim_y = 1;
		dim_z = 1;
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		none_ev = '0;

		// Directed table: extremes, all ops, the covering corner cases.
		probe_ev = '0;
		probe_ev.ev = KIND_STORE;
		probe_ev.base = 64'hFFFF_FFFF_FFFF_FFFF;
		probe_ev.pc = 32'hFFFF_FFFF;
		probe_ev.nbytes = 8'hFF;
		probe_ev.bx = 16'hFFFF;
		probe_ev.by = 16'hFFFF;
		rows.insert(rows.size(), '{mk(OP_ACCESS, 0, 0, 0, KIND_LOAD, 0), 1, none_ev});
		rows.insert(rows.size(), '{mk(OP_REG, 7, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0), 1,
			none_ev});
		rows.insert(rows.size(), '{'{OP_ACCESS, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0,
			KIND_STORE, 10'd1023, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 16'hFFFF}, 1, probe_ev});
		rows.insert(rows.size(), '{mk(OP_REG, 0, 0, 32'hFFFF_FFFF, 0, 0), 0, none_ev});
		rows.insert(rows.size(), '{mk(OP_ACCESS, 0, 64'hFFFF_FFFE, 0, KIND_LOAD, 10'h3FF), 0,
			none_ev});
		rows.insert(rows.size(), '{mk(OP_ACCESS, 0, 64'hFFFF_FFFF, 0, KIND_LOAD, 5), 1,
			none_ev});
		rows.insert(rows.size(), '{mk(OP_REG, 0, 64'h10, 32'h10, 0, 0), 0, none_ev});
		rows.insert(rows.size(), '{mk(OP_ACCESS, 0, 64'h18, 0, KIND_STORE, 9), 0, none_ev});
		rows.insert(rows.size(), '{mk(OP_ACCESS, 0, 64'h20, 0, KIND_LOAD, 9), 0, none_ev});
		rows.insert(rows.size(), '{mk(OP_ACCESS, 0, 64'h18, 0, 2'd0, 9), 1, none_ev});
		rows.insert(rows.size(), '{mk(OP_ACCESS, 0, 64'h18, 0, 2'd3, 9), 1, none_ev});
		rows.insert(rows.size(), '{mk(2'd3, 0, 64'h18, 0, KIND_LOAD, 9), 1, none_ev});
		rows.insert(rows.size(), '{mk(OP_ACCESS, 1, 64'h18, 0, KIND_LOAD, 9), 1, none_ev});
		rows.insert(rows.size(), '{mk(OP_REG, 0, 64'h10, 32'h4, 0, 0), 0, none_ev});
		rows.insert(rows.size(), '{mk(OP_ACCESS, 0, 64'h18, 0, KIND_LOAD, 9), 0, none_ev});
		rows.insert(rows.size(), '{mk(OP_UNREG, 0, 64'h10, 0, 0, 0), 0, none_ev});
		rows.insert(rows.size(), '{mk(OP_UNREG, 0, 64'h10, 0, 0, 0), 0, none_ev});
		for (int i = 0; i < WATCH_ENTRIES; i++)
			rows.insert(rows.size(), '{mk(OP_REG, 3, 64'(i * 64), 32'd64, 0, 0), 0, none_ev});
		foreach (rows[i]) begin
			send_request(rows[i].req);
			if (rows[i].typed && pending_events[$] != rows[i].ev) begin
				$error("directed row %0d: table disagrees with prediction", i);
				errors++;
			end
		end

		// Clear space 3, then unregister bases in spaces 0 and 1, so random traffic can register again.
		for (int i = 0; i < WATCH_ENTRIES; i++)
			send_request(mk(OP_UNREG, 3, 64'(i * 64), 0, 0, 0));
		for (int i = 0; i < WATCH_ENTRIES; i++)
			send_request(mk(OP_UNREG, $urandom_range(1), i == 0 ? 0 : 64'hFFFF_FFFF, 0, 0, 0));

		// Random phases, each with its own dimensions and idling mix.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: write_dims(11'd1024, 11'd1024, 7'd64);
				1: write_dims(11'd0, 11'd2047, 7'd127);
				2: write_dims(11'd1, 11'd1, 7'd1);
				default: write_dims(11'($urandom_range(1, 40)), 11'($urandom_range(1, 30)),
					7'($urandom_range(1, 64)));
			endcase
			idle_in_pct = phase_pcts[ph][0];
			stall_out_pct = phase_pcts[ph][1];
			for (int k = 0; k < 150; k++) begin
				// hold the receiver off mid-phase while requests keep coming
				if (ph == 0 && k == 40)
					fork
						begin
							long_hold = 1'b1;
							repeat (400) @(negedge clk);
							long_hold = 1'b0;
						end
					join_none
				if (ph == 2 && k == 80)
					write_dims(11'($urandom_range(2, 1024)), 11'($urandom_range(2, 1024)),
						7'($urandom_range(2, 64)));
				send_request(random_request());
			end
		end
		in_valid <= 1'b0;
		idle_in_pct = 0;
		stall_out_pct = 0;
		while (pending_events.size() != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
		$display("sent %0d requests, %0d watch hits, %0d table-full refusals", n_sent,
			n_hits, n_full);
		$display("dimensions swept incl. zero and max, four idling mixes plus a long stall");
		if (errors == 0)
			$display("address_range_watchpoint_table_test: clean");
		else
			$display("address_range_watchpoint_table_test: errors");
		$finish;
	end
endmodule

@@ address_range_watchpoint_table.f @@
rtl/awt_pkg.sv
rtl/awt_ctrl.sv
rtl/awt_dpath.sv
rtl/address_range_watchpoint_table.sv
rtl/awt_checker.sv
dv/address_range_watchpoint_table_test.sv
